FILE: design/ssa_pkg.sv
// Shared types, constants and helper functions of the scanline span accumulator.
package ssa_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 1024;

	localparam int POS_W      = 16;
	localparam int FW_W       = 12;
	localparam int FH_W       = 11;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int ENTRY_W    = 1 + 2 * COL_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;
	localparam int LEFT_W     = 12;
	localparam int RIGHT_W    = 11;
	localparam int ROW_LOW_W  = 11;
	localparam int ROW_HIGH_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 12'd2048;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 11'd1024;

	typedef enum logic [1:0] {
		KIND_PLOT  = 2'd0,
		KIND_READ  = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_LOOKUP = 2'd1,
		ST_SWEEP  = 2'd2
	} state_t;

	typedef struct packed {
		logic capture;
		logic clear_start;
		logic plot_wr;
		logic load_out;
		logic sweep_wr;
	} ssa_cmd_t;

	typedef struct packed {
		logic is_plot;
		logic out_busy;
		logic sweep_last;
	} ssa_status_t;

	function automatic logic [FW_W-1:0] eff_width(input logic [FW_W-1:0] w);
		logic [FW_W-1:0] r;
		r = w;
		if (w == '0)
			r = FW_W'(1);
		else if (w > FW_W'(MAX_WIDTH))
			r = FW_W'(MAX_WIDTH);
		return r;
	endfunction

	function automatic logic [FH_W-1:0] eff_height(input logic [FH_W-1:0] h);
		logic [FH_W-1:0] r;
		r = h;
		if (h == '0)
			r = FH_W'(1);
		else if (h > FH_W'(MAX_HEIGHT))
			r = FH_W'(MAX_HEIGHT);
		return r;
	endfunction

	function automatic logic [COL_W-1:0] clamp_col(input logic [POS_W-1:0] x,
		input logic [FW_W-1:0] w);
		logic [COL_W-1:0] r;
		if (x[POS_W-1])
			r = '0;
		else if (x >= POS_W'(w))
			r = COL_W'(w - FW_W'(1));
		else
			r = COL_W'(x);
		return r;
	endfunction

	function automatic logic row_in_frame(input logic [POS_W-1:0] y,
		input logic [FH_W-1:0] h);
		return !y[POS_W-1] && (y < POS_W'(h));
	endfunction

endpackage

FILE: design/ssa_in_if.sv
// Input item channel: kind and signed position with valid/ready handshake.
interface ssa_in_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          kind;
	logic signed [ssa_pkg::POS_W-1:0]    pos_x;
	logic signed [ssa_pkg::POS_W-1:0]    pos_y;

	modport source (output valid, output kind, output pos_x, output pos_y, input ready);
	modport sink (input valid, input kind, input pos_x, input pos_y, output ready);
endinterface

FILE: design/ssa_out_if.sv
// Result item channel: row span and frame row range with valid/ready handshake.
interface ssa_out_if;
	logic                              valid;
	logic                              ready;
	logic [ssa_pkg::LEFT_W-1:0]        span_left;
	logic [ssa_pkg::RIGHT_W-1:0]       span_right;
	logic                              row_empty;
	logic [ssa_pkg::ROW_LOW_W-1:0]     row_low;
	logic [ssa_pkg::ROW_HIGH_W-1:0]    row_high;

	modport source (output valid, output span_left, output span_right, output row_empty,
		output row_low, output row_high, input ready);
	modport sink (input valid, input span_left, input span_right, input row_empty,
		input row_low, input row_high, output ready);
endinterface

FILE: design/ssa_ctrl.sv
// Controller state machine: item acceptance, span lookup/update and clearing pass.
module ssa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [1:0]           in_kind,
	output logic                 in_ready,
	input  ssa_pkg::ssa_status_t status,
	output ssa_pkg::ssa_cmd_t    cmd
);

	ssa_pkg::state_t state_q;
	ssa_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ssa_pkg::ST_SWEEP;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ssa_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (in_kind)
						ssa_pkg::KIND_PLOT:  state_d = ssa_pkg::ST_LOOKUP;
						ssa_pkg::KIND_READ:  state_d = ssa_pkg::ST_LOOKUP;
						ssa_pkg::KIND_CLEAR: state_d = ssa_pkg::ST_SWEEP;
						default:             state_d = ssa_pkg::ST_IDLE;
					endcase
				end
			end
			ssa_pkg::ST_LOOKUP: begin
				if (status.is_plot || !status.out_busy)
					state_d = ssa_pkg::ST_IDLE;
			end
			ssa_pkg::ST_SWEEP: begin
				if (status.sweep_last)
					state_d = ssa_pkg::ST_IDLE;
			end
			default: state_d = ssa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		cmd.capture     = 1'b0;
		cmd.clear_start = 1'b0;
		cmd.plot_wr     = 1'b0;
		cmd.load_out    = 1'b0;
		cmd.sweep_wr    = 1'b0;
		case (state_q)
			ssa_pkg::ST_IDLE: begin
				in_ready        = 1'b1;
				cmd.capture     = in_valid;
				cmd.clear_start = in_valid && (in_kind == ssa_pkg::KIND_CLEAR);
			end
			ssa_pkg::ST_LOOKUP: begin
				cmd.plot_wr  = status.is_plot;
				cmd.load_out = !status.is_plot && !status.out_busy;
			end
			ssa_pkg::ST_SWEEP: begin
				cmd.sweep_wr = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

FILE: design/ssa_datapath.sv
// Datapath: configuration registers, span memory, row range and result register.
module ssa_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ssa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ssa_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [1:0]                       in_kind,
	input  logic [ssa_pkg::POS_W-1:0]        in_pos_x,
	input  logic [ssa_pkg::POS_W-1:0]        in_pos_y,
	input  ssa_pkg::ssa_cmd_t                cmd,
	output ssa_pkg::ssa_status_t             status,
	ssa_out_if.source                        span
);

	logic [ssa_pkg::FW_W-1:0]    width_q;
	logic [ssa_pkg::FH_W-1:0]    height_q;
	logic [ssa_pkg::FW_W-1:0]    eff_w;
	logic [ssa_pkg::FH_W-1:0]    eff_h;

	logic                        is_plot_q;
	logic                        in_frame_q;
	logic [ssa_pkg::ROW_W-1:0]   row_q;
	logic [ssa_pkg::COL_W-1:0]   col_q;

	logic [ssa_pkg::ENTRY_W-1:0] mem [ssa_pkg::MAX_HEIGHT];
	logic [ssa_pkg::ENTRY_W-1:0] rd_q;
	logic                        wr_en;
	logic [ssa_pkg::ROW_W-1:0]   wr_addr;
	logic [ssa_pkg::ENTRY_W-1:0] wr_data;

	logic                        rd_valid;
	logic [ssa_pkg::COL_W-1:0]   rd_lo;
	logic [ssa_pkg::COL_W-1:0]   rd_hi;
	logic [ssa_pkg::COL_W-1:0]   new_lo;
	logic [ssa_pkg::COL_W-1:0]   new_hi;
	logic                        hit;

	logic [ssa_pkg::ROW_W-1:0]   cnt_q;
	logic                        any_row_q;
	logic [ssa_pkg::ROW_W-1:0]   min_row_q;
	logic [ssa_pkg::ROW_W-1:0]   max_row_q;
	logic                        out_valid_q;

	logic [ssa_pkg::LEFT_W-1:0]     left_q;
	logic [ssa_pkg::RIGHT_W-1:0]    right_q;
	logic                           empty_q;
	logic [ssa_pkg::ROW_LOW_W-1:0]  low_q;
	logic [ssa_pkg::ROW_HIGH_W-1:0] high_q;

	assign eff_w = ssa_pkg::eff_width(width_q);
	assign eff_h = ssa_pkg::eff_height(height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ssa_pkg::FRAME_WIDTH_RESET;
			height_q <= ssa_pkg::FRAME_HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ssa_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data[ssa_pkg::FW_W-1:0];
				ssa_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data[ssa_pkg::FH_W-1:0];
				default: ;
			endcase
		end
	end

	// Hold the decoded item for the lookup cycle.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			is_plot_q  <= (in_kind == ssa_pkg::KIND_PLOT);
			in_frame_q <= ssa_pkg::row_in_frame(in_pos_y, eff_h);
			row_q      <= in_pos_y[ssa_pkg::ROW_W-1:0];
			col_q      <= ssa_pkg::clamp_col(in_pos_x, eff_w);
		end
	end

	assign rd_valid = rd_q[ssa_pkg::ENTRY_W-1];
	assign rd_lo    = rd_q[2*ssa_pkg::COL_W-1:ssa_pkg::COL_W];
	assign rd_hi    = rd_q[ssa_pkg::COL_W-1:0];
	assign hit      = in_frame_q && rd_valid;
	assign new_lo   = (!rd_valid || col_q < rd_lo) ? col_q : rd_lo;
	assign new_hi   = (!rd_valid || col_q > rd_hi) ? col_q : rd_hi;

	assign wr_en   = cmd.sweep_wr || (cmd.plot_wr && in_frame_q);
	assign wr_addr = cmd.sweep_wr ? cnt_q : row_q;
	assign wr_data = cmd.sweep_wr ? '0 : {1'b1, new_lo, new_hi};

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			rd_q <= mem[in_pos_y[ssa_pkg::ROW_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (cmd.clear_start)
			cnt_q <= '0;
		else if (cmd.sweep_wr)
			cnt_q <= cnt_q + ssa_pkg::ROW_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_row_q <= 1'b0;
			min_row_q <= '0;
			max_row_q <= '0;
		end else if (cmd.clear_start) begin
			any_row_q <= 1'b0;
		end else if (cmd.plot_wr && in_frame_q) begin
			any_row_q <= 1'b1;
			if (!any_row_q || row_q < min_row_q)
				min_row_q <= row_q;
			if (!any_row_q || row_q > max_row_q)
				max_row_q <= row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (span.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			left_q  <= hit ? ssa_pkg::LEFT_W'(rd_lo) : ssa_pkg::LEFT_W'(eff_w);
			right_q <= hit ? ssa_pkg::RIGHT_W'(rd_hi) : '0;
			empty_q <= !hit;
			low_q   <= any_row_q ? ssa_pkg::ROW_LOW_W'(min_row_q)
				: ssa_pkg::ROW_LOW_W'(eff_h);
			high_q  <= any_row_q ? ssa_pkg::ROW_HIGH_W'(max_row_q) : '0;
		end
	end

	assign span.valid      = out_valid_q;
	assign span.span_left  = left_q;
	assign span.span_right = right_q;
	assign span.row_empty  = empty_q;
	assign span.row_low    = low_q;
	assign span.row_high   = high_q;

	assign status.is_plot    = is_plot_q;
	assign status.out_busy   = out_valid_q && !span.ready;
	assign status.sweep_last = (cnt_q == ssa_pkg::ROW_W'(ssa_pkg::MAX_HEIGHT - 1));

`ifndef SYNTHESIS
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid_q && !span.ready))
		else $error("result register overwritten while still held");

	a_sweep_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sweep_wr && !cmd.clear_start && !status.sweep_last)
		|=> cnt_q == $past(cnt_q) + ssa_pkg::ROW_W'(1))
		else $error("clearing pass skipped a row");

	a_span_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !cmd.sweep_wr) |-> new_lo <= new_hi)
		else $error("stored span has left above right");
`endif

endmodule

FILE: design/scanline_span_accumulator_top.sv
// Top level of the scanline span accumulator: controller, datapath and channel ports.
//
// A plot or read item is handled in the accept cycle, which issues the span memory
// read, then in the lookup state, which does the read-modify-write of the row entry
// or loads the result register; no item is accepted until the lookup state ends, so
// items do not overlap in the single span memory. A read item holds in the lookup
// state while the previous result has not been taken. Kind 3 is accepted and dropped.
// A clear item, and reset, start a clearing pass that rewrites every row of the span
// memory, during which no item is accepted; configuration writes are taken at any time.
module scanline_span_accumulator_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ssa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ssa_pkg::CFG_DATA_W-1:0]   cfg_data,
	ssa_in_if.sink                           cmd,
	ssa_out_if.source                        span
);

	ssa_pkg::ssa_cmd_t    dp_cmd;
	ssa_pkg::ssa_status_t dp_status;
	logic                 in_ready;

	assign cmd.ready = in_ready;

	ssa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_kind  (cmd.kind),
		.in_ready (in_ready),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	ssa_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_kind   (cmd.kind),
		.in_pos_x  (cmd.pos_x),
		.in_pos_y  (cmd.pos_y),
		.cmd       (dp_cmd),
		.status    (dp_status),
		.span      (span)
	);

endmodule
